/* src/desr_pkg.sv */
`default_nettype none

package desr_pkg;

   // Field widths of the data path.
   localparam int BLOCK_W = 64;
   localparam int HALF_W  = 32;
   localparam int KEY_W   = 48;
   localparam int OP_W    = 2;

   // Operation codes carried by each request beat.
   typedef enum logic [OP_W-1:0] {
      OP_IP    = 2'd0,
      OP_ROUND = 2'd1,
      OP_FP    = 2'd2,
      OP_PASS  = 2'd3
   } op_type;

   // Permutation tables; entry value 1 names the most significant source bit.
   localparam logic [6:0] IP_TAB [64] = '{
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
      7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
   };

   localparam logic [6:0] FP_TAB [64] = '{
      7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
      7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
      7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
      7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
      7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
      7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
      7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
      7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
   };

   localparam logic [5:0] E_TAB [48] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
      6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
      6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
      6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
      6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   localparam logic [5:0] P_TAB [32] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
   };

   // Substitution boxes S1 to S8, each indexed by row * 16 + column.
   localparam logic [3:0] S_TAB [8][64] = '{
      '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
        4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
        4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
        4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
        4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
        4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
        4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
      '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
        4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
        4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
        4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
        4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
        4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
        4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
        4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
      '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
        4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
        4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
        4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
        4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
        4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
        4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
        4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
      '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
        4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
        4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
        4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
        4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
        4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
        4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
        4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
      '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
        4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
        4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
        4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
        4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
        4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
        4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
        4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
      '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
        4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
        4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
        4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
        4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
        4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
        4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
        4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
      '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
        4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
        4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
        4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
        4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
        4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
        4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
        4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
      '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
        4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
        4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
        4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
        4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
        4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
        4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
        4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
   };

   // Initial permutation: output bit 63-i takes source bit 64-IP_TAB[i].
   function automatic logic [BLOCK_W-1:0] ip_perm(input logic [BLOCK_W-1:0] src);
      logic [BLOCK_W-1:0] r;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[BLOCK_W-1-i] = src[6'(7'd64 - IP_TAB[i])];
      end
      return r;
   endfunction

   // Final permutation, the inverse of the initial one.
   function automatic logic [BLOCK_W-1:0] fp_perm(input logic [BLOCK_W-1:0] src);
      logic [BLOCK_W-1:0] r;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[BLOCK_W-1-i] = src[6'(7'd64 - FP_TAB[i])];
      end
      return r;
   endfunction

   // Expansion of the right half from 32 to 48 bits.
   function automatic logic [KEY_W-1:0] e_expand(input logic [HALF_W-1:0] src);
      logic [KEY_W-1:0] r;
      for (int i = 0; i < KEY_W; i++) begin
         r[KEY_W-1-i] = src[5'(6'd32 - E_TAB[i])];
      end
      return r;
   endfunction

   // Permutation of the substitution output.
   function automatic logic [HALF_W-1:0] p_perm(input logic [HALF_W-1:0] src);
      logic [HALF_W-1:0] r;
      for (int i = 0; i < HALF_W; i++) begin
         r[HALF_W-1-i] = src[5'(6'd32 - P_TAB[i])];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/desr_perm.sv */
`default_nettype none

module desr_perm (
   input  wire desr_pkg::op_type                  op,
   input  wire logic [desr_pkg::BLOCK_W-1:0]     block_in,
   output logic      [desr_pkg::BLOCK_W-1:0]     block_out
);
   import desr_pkg::*;

   // Initial or final permutation; the final one is chosen only by its own code.
   always_comb begin
      if (op == OP_FP) begin
         block_out = fp_perm(block_in);
      end else begin
         block_out = ip_perm(block_in);
      end
   end

endmodule

`default_nettype wire

/* src/desr_feistel.sv */
`default_nettype none

module desr_feistel (
   input  wire logic [desr_pkg::BLOCK_W-1:0] block_in,
   input  wire logic [desr_pkg::KEY_W-1:0]   round_key,
   output logic      [desr_pkg::BLOCK_W-1:0] block_out
);
   import desr_pkg::*;

   logic [HALF_W-1:0] left;
   logic [HALF_W-1:0] right;
   logic [KEY_W-1:0]  mixed;
   logic [HALF_W-1:0] sbox_out;

   assign left  = block_in[BLOCK_W-1:HALF_W];
   assign right = block_in[HALF_W-1:0];

   // Expand the right half and mix in the round key.
   assign mixed = e_expand(right) ^ round_key;

   // Eight independent S-box lookups; row from the outer bits, column from the inner four.
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         sbox_out[HALF_W-1-4*b -: 4] =
            S_TAB[b][{mixed[KEY_W-1-6*b], mixed[KEY_W-6-6*b], mixed[KEY_W-2-6*b -: 4]}];
      end
   end

   // The right half moves up; the new right half is the old left XOR f.
   assign block_out = {right, left ^ p_perm(sbox_out)};

endmodule

`default_nettype wire

/* src/des_round_datapath_core.sv */
`default_nettype none

// DES data-path unit: initial permutation, one Feistel round or final
// permutation on a 64-bit block, one operation per request beat.
// Request channel: drive start high with req_type, req_data_block and
// req_round_key; the beat is taken at that clock edge. busy is held low, so
// a new request beat can be issued in every cycle.
// Result channel: rsp_result_block is shown for one cycle with rsp_strobe
// high; each request passes the input register, then the result register,
// on its way there, and the receiver captures the result at the clock edge
// where rsp_strobe is high. Results leave in request order, one per request.
// Throughput is one beat per cycle; the path between the two registers is a
// permutation, or the expansion, S-box lookup and P permutation of a round.
// Operation code 3 returns the block unchanged; the round key matters only
// to the round operation.
// Reset clears both valid flags, so no result strobe follows reset until a
// new request is taken. The receiver cannot stall this block, so nothing is
// held back and no result is ever dropped.
module des_round_datapath_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [desr_pkg::OP_W-1:0]        req_type,
   input  wire logic [desr_pkg::BLOCK_W-1:0]     req_data_block,
   input  wire logic [desr_pkg::KEY_W-1:0]       req_round_key,
   output logic                                  rsp_strobe,
   output logic      [desr_pkg::BLOCK_W-1:0]     rsp_result_block
);
   import desr_pkg::*;

   logic               req_valid_ff;
   logic               req_valid_in;
   op_type             op_ff;
   logic [BLOCK_W-1:0] block_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [BLOCK_W-1:0] perm_block;
   logic [BLOCK_W-1:0] round_block;
   logic               rsp_valid_ff;
   logic [BLOCK_W-1:0] result_ff;
   logic [BLOCK_W-1:0] result_in;

   // The unit never refuses a beat.
   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         op_ff    <= op_type'(req_type);
         block_ff <= req_data_block;
         key_ff   <= req_round_key;
      end
   end

   desr_perm u_perm (
      .op        (op_ff),
      .block_in  (block_ff),
      .block_out (perm_block)
   );

   desr_feistel u_feistel (
      .block_in  (block_ff),
      .round_key (key_ff),
      .block_out (round_block)
   );

   // Select the result of the requested operation.
   always_comb begin
      unique case (op_ff)
         OP_IP:    result_in = perm_block;
         OP_ROUND: result_in = round_block;
         OP_FP:    result_in = perm_block;
         OP_PASS:  result_in = block_ff;
         default:  result_in = block_ff;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_result_block = result_ff;

endmodule

`default_nettype wire
